### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied.
`define PPDAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PPDAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/ppdac_pkg.sv
`timescale 1ns / 1ps

package ppdac_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ZERO  = '0;
  localparam logic [PTR_W-1:0] WR_RESET  = PTR_W'(1 % FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

  localparam int         SELECT_BIT  = 3;
  localparam int         ACK_BIT     = 6;
  localparam logic [7:0] SILENT_BYTE = 8'h80;

  typedef enum logic [1:0] {
    OP_WRITE_DATA    = 2'd0,
    OP_READ_STATUS   = 2'd1,
    OP_WRITE_CONTROL = 2'd2,
    OP_TICK          = 2'd3
  } opcode_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } fifo_cmd_t;

  typedef struct packed {
    logic       full;
    logic       multi;   // more than one entry held
    logic [7:0] front;
  } fifo_stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = PTR_ZERO;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

### rtl/ppdac_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppdac_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppdac_pkg::fifo_cmd_t  cmd,
  output ppdac_pkg::fifo_stat_t stat
);
  import ppdac_pkg::*;

  logic [7:0]       store_r [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      wr_nxt  = ptr_next(wr_r);
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      rd_nxt  = ptr_next(rd_r);
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= PTR_ZERO;
      wr_r  <= WR_RESET;
      cnt_r <= CNT_ONE;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry 0 holds the silent byte after reset; others are written before use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r[0] <= SILENT_BYTE;
    end else if (cmd.push) begin
      store_r[wr_r] <= cmd.push_data;
    end
  end

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.multi = (cnt_r > CNT_ONE);
  assign stat.front = store_r[rd_r];

  `PPDAC_ASSERT(a_cnt_range, (cnt_r >= CNT_ONE) && (cnt_r <= CNT_FULL), "fill count out of range")
  `PPDAC_ASSERT(a_no_push_full, cmd.push |-> !stat.full, "push into full FIFO")
  `PPDAC_ASSERT(a_no_pop_last, cmd.pop |-> stat.multi, "pop of last entry")
  `PPDAC_ASSERT(a_full_ptrs, stat.full |-> (rd_r == wr_r), "pointers disagree when full")

endmodule

### rtl/ppdac_bus.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppdac_bus (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [1:0]            in_opcode,
  input  logic [7:0]            in_bus_value,
  input  ppdac_pkg::fifo_stat_t stat,
  output ppdac_pkg::fifo_cmd_t  cmd,
  output logic                  out_valid,
  output logic [7:0]            out_status_byte,
  output logic signed [15:0]    out_sample_value
);
  import ppdac_pkg::*;

  logic               in_valid_r;
  opcode_t            op_r;
  logic [7:0]         bus_r;
  logic [7:0]         data_r, data_nxt;
  logic [7:0]         ctrl_r, ctrl_nxt;
  logic               out_valid_r;
  logic [7:0]         status_r, status_nxt;
  logic signed [15:0] sample_r, sample_nxt;

  always_comb begin
    cmd        = '0;
    data_nxt   = data_r;
    ctrl_nxt   = ctrl_r;
    status_nxt = '0;
    sample_nxt = '0;
    cmd.push_data = data_r;
    if (in_valid_r) begin
      unique case (op_r)
        OP_WRITE_DATA: begin
          data_nxt = bus_r;
        end
        OP_READ_STATUS: begin
          status_nxt[ACK_BIT] = stat.full;
        end
        OP_WRITE_CONTROL: begin
          // select rising edge latches the data byte
          cmd.push = !ctrl_r[SELECT_BIT] && bus_r[SELECT_BIT] && !stat.full;
          ctrl_nxt = bus_r;
        end
        OP_TICK: begin
          sample_nxt = {stat.front ^ SILENT_BYTE, 8'h00};
          cmd.pop    = stat.multi;
        end
        default: begin
          sample_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      data_r      <= SILENT_BYTE;
      ctrl_r      <= '0;
    end else begin
      in_valid_r  <= in_fire;
      out_valid_r <= in_valid_r;
      data_r      <= data_nxt;
      ctrl_r      <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= opcode_t'(in_opcode);
      bus_r <= in_bus_value;
    end
    status_r <= status_nxt;
    sample_r <= sample_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status_byte  = status_r;
  assign out_sample_value = sample_r;

  `PPDAC_ASSERT(a_res_follows, in_valid_r |=> out_valid_r, "transaction lost")
  `PPDAC_ASSERT(a_no_spurious, !in_valid_r |=> !out_valid_r, "result without transaction")
  `PPDAC_ASSERT(a_push_src, cmd.push |-> (in_valid_r && (op_r == OP_WRITE_CONTROL)), "stray push")

endmodule

### rtl/parallel_port_audio_dac_fifo_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         start (taken when !busy)  in_opcode[1:0], in_bus_value[7:0]
// result    out        out_valid strobe          out_status_byte[7:0], out_sample_value[15:0]
//
// One transaction accepted per cycle; busy stays low after reset.
// Each result passes the input register, then FIFO/latch logic into the result
// register.
// rst_n is synchronous: the FIFO holds one silent byte, data latch = 0x80.
// The receiver cannot stall; every result is a one-cycle out_valid pulse.

module parallel_port_audio_dac_fifo_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_bus_value,
  output logic               out_valid,
  output logic [7:0]         out_status_byte,
  output logic signed [15:0] out_sample_value
);
  import ppdac_pkg::*;

  fifo_cmd_t  fifo_cmd;
  fifo_stat_t fifo_stat;
  logic       in_fire;

  // Every opcode completes in one pass, so the port never pushes back.
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Bus decode, data/control latches and the result register.
  ppdac_bus u_bus (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_opcode        (in_opcode),
    .in_bus_value     (in_bus_value),
    .stat             (fifo_stat),
    .cmd              (fifo_cmd),
    .out_valid        (out_valid),
    .out_status_byte  (out_status_byte),
    .out_sample_value (out_sample_value)
  );

  // Sample FIFO: never runs empty, the last byte is repeated on ticks.
  ppdac_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fifo_cmd),
    .stat  (fifo_stat)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppdac_pkg::*;

  // Run limits
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_OPS   = 1950;
  localparam int QUIET_TAIL   = 150;    // last transactions go back to back
  localparam int MAX_PRINTS   = 40;

  // Bus transaction waiting to be driven
  typedef struct {
    opcode_t    op;
    logic [7:0] bus;
    bit         wait_idle; // hold off until every reply is back
  } bus_op_t;

  // Reply the core is expected to give
  typedef struct {
    opcode_t           op;
    logic [7:0]        status;
    logic signed [15:0] sample;
  } dac_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = OP_WRITE_DATA;
  logic [7:0]         in_bus_value = 8'h00;
  logic               out_valid;
  logic [7:0]         out_status_byte;
  logic signed [15:0] out_sample_value;

  parallel_port_audio_dac_fifo_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_bus_value     (in_bus_value),
    .out_valid        (out_valid),
    .out_status_byte  (out_status_byte),
    .out_sample_value (out_sample_value)
  );

  always #1 clk = ~clk;

  bus_op_t    bus_ops_q[$];
  dac_reply_t dac_reply_q[$];

  int  mismatch_count = 0;
  int  ops_queued = 0;
  bit  hold_next = 1'b0;

  // Handshake counts, written by the monitor with NBAs so the driver sees
  // a stable value at every edge
  int  n_accepted = 0;
  int  n_checked = 0;

  // Driver pacing
  int  gap_left = 0;
  int  gap_odds = 0;   // one gap per gap_odds transactions on average, 0 = none
  int  drv_count = 0;
  int  cycle_count = 0;

  // Shadow of the core: latches and sample FIFO
  logic [7:0] sh_data;
  logic [7:0] sh_ctrl;
  logic [7:0] sh_store [FIFO_DEPTH];
  int         sh_rd;
  int         sh_wr;
  int         sh_fill;

  // What the run exercised
  int  n_pushed, n_dropped, n_full_reads, n_held_ticks, n_ticks, n_rd_wraps;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function automatic int wrap_inc(input int p);
    return (p == FIFO_DEPTH - 1) ? 0 : p + 1;
  endfunction

  task automatic reset_shadow();
    sh_data = SILENT_BYTE;
    sh_ctrl = 8'h00;
    foreach (sh_store[i]) sh_store[i] = 8'h00;
    sh_store[0] = SILENT_BYTE;
    sh_rd = 0;
    sh_wr = 1 % FIFO_DEPTH;
    sh_fill = 1;
  endtask

  // Applies one bus transaction to the shadow and returns the reply it gives
  function automatic dac_reply_t predict_dac_reply(input opcode_t op, input logic [7:0] bus);
    dac_reply_t r;
    logic [7:0] front;
    r.op = op;
    r.status = 8'h00;
    r.sample = 16'sd0;
    case (op)
      OP_WRITE_DATA: begin
        sh_data = bus;
      end
      OP_READ_STATUS: begin
        if (sh_fill >= FIFO_DEPTH) begin
          r.status = 8'h40;
          n_full_reads++;
        end
      end
      OP_WRITE_CONTROL: begin
        // push only on a rising edge of select
        if (!sh_ctrl[SELECT_BIT] && bus[SELECT_BIT]) begin
          if (sh_fill < FIFO_DEPTH) begin
            sh_store[sh_wr] = sh_data;
            sh_wr = wrap_inc(sh_wr);
            sh_fill++;
            n_pushed++;
          end else begin
            n_dropped++;
          end
        end
        sh_ctrl = bus;
      end
      default: begin
        front = sh_store[sh_rd];
        r.sample = {~front[7], front[6:0], 8'h00};
        n_ticks++;
        if (sh_fill > 1) begin
          if (sh_rd == FIFO_DEPTH - 1) n_rd_wraps++;
          sh_rd = wrap_inc(sh_rd);
          sh_fill--;
        end else begin
          n_held_ticks++;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one transaction per start, gaps in random bursts
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic    drive_next;
    bus_op_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      drive_next = 1'b0;
      if (start && busy) begin
        drive_next = 1'b1;             // not taken yet, keep it up
      end else begin
        if (start) begin
          drv_count++;
          // change the gap pattern now and then, quiet stretches included
          if (drv_count % 128 == 0) begin
            case ($urandom_range(0, 3))
              0: gap_odds = 0;
              1: gap_odds = 3;
              2: gap_odds = 6;
              default: gap_odds = 12;
            endcase
          end
          if (bus_ops_q.size() > QUIET_TAIL && gap_odds != 0 &&
              $urandom_range(1, gap_odds) == 1) begin
            gap_left = $urandom_range(1, 10);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (bus_ops_q.size() > 0) begin
          // a flagged transaction waits until the core has gone quiet
          if (!(bus_ops_q[0].wait_idle && (start || n_checked != n_accepted))) begin
            nxt = bus_ops_q.pop_front();
            in_opcode <= nxt.op;
            in_bus_value <= nxt.bus;
            drive_next = 1'b1;
          end
        end
      end
      start <= drive_next;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks the reply strobe, then predicts for the accepted
  // transaction. Both in one block so ordering is fixed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    dac_reply_t exp_r;
    if (!rst_n) begin
      reset_shadow();
      dac_reply_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (dac_reply_q.size() == 0) begin
          report_mismatch($sformatf("reply with none outstanding (status %02h sample %0d)",
                                    out_status_byte, out_sample_value));
        end else begin
          exp_r = dac_reply_q.pop_front();
          if (out_status_byte !== exp_r.status) begin
            report_mismatch($sformatf("%s: status_byte %02h, want %02h",
                                      exp_r.op.name(), out_status_byte, exp_r.status));
          end
          if (out_sample_value !== exp_r.sample) begin
            report_mismatch($sformatf("%s: sample_value %0d, want %0d",
                                      exp_r.op.name(), out_sample_value, exp_r.sample));
          end
        end
        n_checked <= n_checked + 1;
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid unknown");
      end
      if (start && busy === 1'b0) begin
        dac_reply_q.push_back(predict_dac_reply(opcode_t'(in_opcode), in_bus_value));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic add_op(input opcode_t op, input logic [7:0] v);
    bus_op_t b;
    b.op = op;
    b.bus = v;
    b.wait_idle = hold_next;
    hold_next = 1'b0;
    bus_ops_q.push_back(b);
    ops_queued++;
  endtask

  // Well-formed push: data byte, select low, select high
  task automatic add_push();
    add_op(OP_WRITE_DATA, 8'($urandom));
    add_op(OP_WRITE_CONTROL, 8'($urandom) & 8'hF7);
    add_op(OP_WRITE_CONTROL, 8'($urandom) | 8'h08);
  endtask

  task automatic add_ticks(input int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) add_op(OP_READ_STATUS, 8'($urandom));
      else add_op(OP_TICK, 8'($urandom));
    end
  endtask

  initial begin
    int mode;
    int base;

    // directed opening
    add_op(OP_READ_STATUS, 8'hFF);      // empty-ish FIFO, ignored bus byte
    add_op(OP_TICK, 8'h00);             // silent byte with one entry held
    add_op(OP_TICK, 8'hFF);             // repeated
    add_op(OP_WRITE_DATA, 8'h00);
    add_op(OP_WRITE_CONTROL, 8'h08);    // rising select pushes 0x00
    add_op(OP_WRITE_CONTROL, 8'hFF);    // select held high, no push
    add_op(OP_WRITE_CONTROL, 8'hF7);    // select falling, no push
    add_op(OP_WRITE_DATA, 8'hFF);
    add_op(OP_WRITE_CONTROL, 8'h08);    // pushes 0xFF
    add_op(OP_WRITE_CONTROL, 8'h00);
    add_op(OP_WRITE_DATA, 8'h7F);
    add_op(OP_WRITE_CONTROL, 8'h08);    // pushes 0x7F
    add_op(OP_TICK, 8'h00);             // silent
    add_op(OP_TICK, 8'h00);             // most negative
    add_op(OP_TICK, 8'h00);             // most positive
    add_op(OP_TICK, 8'h00);             // 0x7F, one entry left
    add_op(OP_TICK, 8'h00);             // 0x7F again
    add_op(OP_READ_STATUS, 8'h00);
    add_op(OP_WRITE_DATA, 8'h80);
    add_op(OP_WRITE_CONTROL, 8'h00);    // select falling, no push

    // random part; opens with a fill past full after the core goes quiet
    base = ops_queued;
    hold_next = 1'b1;
    repeat (17) add_push();
    add_op(OP_READ_STATUS, 8'($urandom));
    add_ticks(20);
    while (ops_queued - base < RANDOM_OPS) begin
      if (ops_queued - base > RANDOM_OPS / 2 && ops_queued - base < RANDOM_OPS / 2 + 8) begin
        hold_next = 1'b1;
      end
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 20)) begin
            add_push();
            if ($urandom_range(0, 3) == 0) add_op(OP_TICK, 8'($urandom));
            if ($urandom_range(0, 4) == 0) add_op(OP_READ_STATUS, 8'($urandom));
          end
        end
        4, 5: add_ticks($urandom_range(1, 24));
        6: begin
          repeat (17) add_push();
          add_op(OP_READ_STATUS, 8'($urandom));
          add_ticks($urandom_range(1, 20));
        end
        7: begin
          // select glitches: held, falling, rising with random other bits
          repeat ($urandom_range(2, 10)) begin
            if ($urandom_range(0, 2) == 0) add_op(OP_WRITE_DATA, 8'($urandom));
            add_op(OP_WRITE_CONTROL, 8'($urandom));
          end
        end
        default: begin
          repeat ($urandom_range(1, 15)) begin
            add_op(opcode_t'($urandom_range(0, 3)), 8'($urandom));
          end
        end
      endcase
    end

    // reset, then let the driver run
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (bus_ops_q.size() != 0 || start || n_checked != n_accepted);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (dac_reply_q.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", dac_reply_q.size()));
    end

    $display("Covered %0d transactions: %0d pushes, %0d dropped when full, %0d full reads",
             n_accepted, n_pushed, n_dropped, n_full_reads);
    $display("Ticks %0d, %0d on a single entry, %0d read-pointer wraps; %0d mismatches",
             n_ticks, n_held_ticks, n_rd_wraps, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
